// ----- rtl/keyboard_uart_receive_fifo_model_defines.svh -----
// Assertion macros for the keyboard serial interface.
`ifndef KEYBOARD_UART_RECEIVE_FIFO_MODEL_DEFINES_SVH
`define KEYBOARD_UART_RECEIVE_FIFO_MODEL_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define KBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define KBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define KBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/kbd_pkg.sv -----
package kbd_pkg;

  localparam int unsigned RING_DEPTH_DEF = 16;
  // Most ring writes one step can cause: two hello pairs.
  localparam int unsigned NUM_WR = 4;

  typedef enum logic [2:0] {
    FN_BYTE_RD = 3'd0,
    FN_BYTE_WR = 3'd1,
    FN_WORD_RD = 3'd2,
    FN_WORD_WR = 3'd3,
    FN_PUSH    = 3'd4
  } func_t;

  // What a ring slot reads back as: the stored byte or one of the hello bytes.
  typedef enum logic [1:0] {
    TAG_DATA   = 2'd0,
    TAG_HELLO0 = 2'd1,
    TAG_HELLO1 = 2'd2
  } ring_tag_t;

  localparam int unsigned SR_RDRF = 0;
  localparam int unsigned SR_TDRE = 1;
  localparam int unsigned SR_IRQ  = 7;

  localparam logic [7:0] SR_MRESET  = 8'h0E;
  localparam logic [7:0] SR_RESET   = 8'h8F;
  localparam logic [7:0] HELLO_B0   = 8'hF0;
  localparam logic [7:0] HELLO_B1   = 8'h01;
  localparam logic [7:0] TX_HELLO   = 8'h80;
  localparam logic [7:0] EMPTY_BYTE = 8'hFF;
  localparam logic [1:0] CR_MRESET  = 2'b11;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] control;
    logic [7:0] last_tx;
  } csr_t;

endpackage

// ----- rtl/kbd_step.sv -----
module kbd_step import kbd_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  localparam int unsigned IDX_W = $clog2(RING_DEPTH)
) (
  input  func_t                        func_i,
  input  logic [1:0]                   reg_offset_i,
  input  logic [15:0]                  data_in_i,
  input  logic [IDX_W-1:0]             head_i,
  input  logic [IDX_W-1:0]             tail_i,
  input  csr_t                         csr_i,
  input  ring_tag_t                    tail_tag_i,
  input  logic [7:0]                   tail_mem_i,
  output logic [IDX_W-1:0]             head_o,
  output logic [IDX_W-1:0]             tail_o,
  output csr_t                         csr_o,
  output logic [NUM_WR-1:0]            ring_wen_o,
  output logic [NUM_WR-1:0][IDX_W-1:0] ring_widx_o,
  output ring_tag_t [NUM_WR-1:0]       ring_wtag_o,
  output logic                         mem_we_o,
  output logic [15:0]                  read_data_o,
  output logic                         irq_o
);

  localparam int unsigned WC_W = $clog2(NUM_WR + 1);
  localparam int unsigned WI_W = $clog2(NUM_WR);

  typedef struct packed {
    logic [IDX_W-1:0]             head;
    logic [IDX_W-1:0]             tail;
    csr_t                         csr;
    logic [NUM_WR-1:0]            wen;
    logic [NUM_WR-1:0][IDX_W-1:0] widx;
    ring_tag_t [NUM_WR-1:0]       wtag;
    logic [WC_W-1:0]              wcnt;
  } st_t;

  function automatic logic [IDX_W-1:0] idx_next(logic [IDX_W-1:0] i);
    return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic st_t ring_push(st_t s, ring_tag_t k);
    st_t r;
    r = s;
    if (idx_next(s.head) != s.tail && s.wcnt != WC_W'(NUM_WR)) begin
      r.wen[s.wcnt[WI_W-1:0]]  = 1'b1;
      r.widx[s.wcnt[WI_W-1:0]] = s.head;
      r.wtag[s.wcnt[WI_W-1:0]] = k;
      r.wcnt                   = s.wcnt + 1'b1;
      r.head                   = idx_next(s.head);
      r.csr.status[SR_RDRF]    = 1'b1;
      r.csr.status[SR_IRQ]     = 1'b1;
    end
    return r;
  endfunction

  function automatic st_t bus_write(st_t s, logic [1:0] off, logic [7:0] v);
    st_t r;
    r = s;
    if (!off[1]) begin
      if (v[1:0] == CR_MRESET) begin
        r.csr.status = SR_MRESET;
        r.head       = '0;
        r.tail       = '0;
        r            = ring_push(r, TAG_HELLO0);
        r            = ring_push(r, TAG_HELLO1);
      end
      r.csr.control = v;
    end else begin
      r.csr.last_tx = v;
      if (v == TX_HELLO) begin
        r = ring_push(r, TAG_HELLO0);
        r = ring_push(r, TAG_HELLO1);
      end
      r.csr.status[SR_TDRE] = 1'b1;
      r.csr.status[SR_IRQ]  = r.csr.status[SR_RDRF];
    end
    return r;
  endfunction

  st_t        s;
  logic [7:0] b;
  logic [7:0] tail_byte;

  always_comb begin
    case (tail_tag_i)
      TAG_HELLO0: tail_byte = HELLO_B0;
      TAG_HELLO1: tail_byte = HELLO_B1;
      default:    tail_byte = tail_mem_i;
    endcase
  end

  always_comb begin
    s      = '0;
    s.head = head_i;
    s.tail = tail_i;
    s.csr  = csr_i;
    b      = EMPTY_BYTE;
    read_data_o = '0;
    case (func_i)
      FN_BYTE_RD, FN_WORD_RD: begin
        if (!reg_offset_i[1]) begin
          b = csr_i.status;
        end else if (head_i != tail_i) begin
          // pop one byte, drop RDRF once the ring runs dry
          b      = tail_byte;
          s.tail = idx_next(tail_i);
          if (s.tail == head_i) begin
            s.csr.status[SR_RDRF] = 1'b0;
          end
          s.csr.status[SR_IRQ] = s.csr.status[SR_RDRF];
        end
        read_data_o = (func_i == FN_WORD_RD) ? {b, b} : {8'h00, b};
      end
      FN_BYTE_WR: s = bus_write(s, reg_offset_i, data_in_i[7:0]);
      FN_WORD_WR: begin
        s = bus_write(s, reg_offset_i, data_in_i[15:8]);
        s = bus_write(s, reg_offset_i + 2'd1, data_in_i[7:0]);
      end
      FN_PUSH:    s = ring_push(s, TAG_DATA);
      default: ;
    endcase
  end

  assign head_o      = s.head;
  assign tail_o      = s.tail;
  assign csr_o       = s.csr;
  assign ring_wen_o  = s.wen;
  assign ring_widx_o = s.widx;
  assign ring_wtag_o = s.wtag;
  // a received byte is the only write that lands in the data store
  assign mem_we_o    = (func_i == FN_PUSH) && s.wen[0];
  assign irq_o       = s.csr.status[SR_IRQ];

endmodule

// ----- rtl/keyboard_uart_receive_fifo_model.sv -----
// Keyboard serial interface, 6850 style, with a receive ring.
// Input channel: in_tuser carries the function (byte/word read or write,
// or a push of a received byte); in_tdata carries the register offset and
// the write or push data. Every transfer in gives exactly one transfer out:
// out_tdata holds the read data and the interrupt request after the step.
// The ring has RING_DEPTH slots and holds up to RING_DEPTH-1 bytes; a push
// into a full ring is dropped.
// An item is taken into the input register, worked on by the register
// updates and ring access, and shown in the output register. Throughput is
// one item per cycle while out_tready is high or the output register is
// empty; the ring data store has one write and one read port and its read
// word for the current tail is kept ready in a register.
// Reset (rst_n low, synchronous) empties the ring, queues the bytes F0 and
// 01 and sets status to 0x8F, control and last transmit byte to zero.
// When the receiver holds out_tready low the output register keeps its
// item, the input register fills, then in_tready drops until it drains.
module keyboard_uart_receive_fifo_model import kbd_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  localparam int unsigned IDX_W = $clog2(RING_DEPTH)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [1:0] reg_offset, [17:2] data_in, [23:18] zero
  input  logic [2:0]  in_tuser,   // [2:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [15:0] read_data, [16] irq_out, [23:17] zero
);

  `include "keyboard_uart_receive_fifo_model_defines.svh"

  // input register
  logic        in_v_r;
  func_t       func_r;
  logic [1:0]  off_r;
  logic [15:0] dat_r;

  // output register
  logic        out_v_r;
  logic [15:0] rd_r;
  logic        irq_r;

  // block state
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt, tail_step;
  csr_t             csr_r, csr_nxt;
  ring_tag_t        tag_r [RING_DEPTH];
  ring_tag_t        tag_nxt [RING_DEPTH];
  logic [7:0]       ring_mem [RING_DEPTH];
  logic [7:0]       mem_rd_r;

  logic                         adv;
  logic [NUM_WR-1:0]            ring_wen;
  logic [NUM_WR-1:0][IDX_W-1:0] ring_widx;
  ring_tag_t [NUM_WR-1:0]       ring_wtag;
  logic                         mem_we;
  logic [15:0]                  rd_nxt;
  logic                         irq_nxt;

  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  kbd_step #(.RING_DEPTH(RING_DEPTH)) u_step (
    .func_i       (func_r),
    .reg_offset_i (off_r),
    .data_in_i    (dat_r),
    .head_i       (head_r),
    .tail_i       (tail_r),
    .csr_i        (csr_r),
    .tail_tag_i   (tag_r[tail_r]),
    .tail_mem_i   (mem_rd_r),
    .head_o       (head_nxt),
    .tail_o       (tail_step),
    .csr_o        (csr_nxt),
    .ring_wen_o   (ring_wen),
    .ring_widx_o  (ring_widx),
    .ring_wtag_o  (ring_wtag),
    .mem_we_o     (mem_we),
    .read_data_o  (rd_nxt),
    .irq_o        (irq_nxt)
  );

  always_comb begin
    if (!rst_n) begin
      tail_nxt = '0;
    end else if (adv) begin
      tail_nxt = tail_step;
    end else begin
      tail_nxt = tail_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= func_t'(in_tuser);
      off_r  <= in_tdata[1:0];
      dat_r  <= in_tdata[17:2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r  <= rd_nxt;
      irq_r <= irq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= IDX_W'(2);
      tail_r <= '0;
      csr_r  <= '{status: SR_RESET, control: 8'h00, last_tx: 8'h00};
    end else begin
      tail_r <= tail_nxt;
      if (adv) begin
        head_r <= head_nxt;
        csr_r  <= csr_nxt;
      end
    end
  end

  // slot tags: later writes of one step win, so a master reset overrides earlier writes
  always_comb begin
    tag_nxt = tag_r;
    if (adv) begin
      for (int k = 0; k < NUM_WR; k++) begin
        if (ring_wen[k]) begin
          tag_nxt[ring_widx[k]] = ring_wtag[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        if (i == 0) begin
          tag_r[i] <= TAG_HELLO0;
        end else if (i == 1) begin
          tag_r[i] <= TAG_HELLO1;
        end else begin
          tag_r[i] <= TAG_DATA;
        end
      end
    end else begin
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && mem_we) begin
      ring_mem[ring_widx[0]] <= dat_r[7:0];
    end
  end

  // keep the byte at the tail ready, forwarding a write to that slot
  always_ff @(posedge clk) begin
    if (adv && mem_we && ring_widx[0] == tail_nxt) begin
      mem_rd_r <= dat_r[7:0];
    end else begin
      mem_rd_r <= ring_mem[tail_nxt];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, irq_r, rd_r};

  `KBD_ASSERT_NOW(a_irq_follows_rdrf, clk, rst_n, 1'b1,
    csr_r.status[SR_IRQ] == csr_r.status[SR_RDRF], "IRQ does not follow RDRF")
  `KBD_ASSERT_NOW(a_rdrf_matches_ring, clk, rst_n, 1'b1,
    csr_r.status[SR_RDRF] == (head_r != tail_r), "RDRF disagrees with ring fill")
  `KBD_ASSERT_NEXT(a_tdre_kept, clk, rst_n, 1'b1,
    csr_r.status[SR_TDRE], "TDRE cleared")

endmodule

// ----- tb/sv/keyboard_uart_receive_fifo_model_tb.sv -----
module keyboard_uart_receive_fifo_model_tb import kbd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDX_W     = $clog2(RING_DEPTH_DEF);
  localparam int unsigned IDLE_PCT  = 24;
  localparam int unsigned N_RANDOM  = 650;
  localparam int unsigned MAX_CYC   = 200000;
  localparam int unsigned MAX_SHOWN = 10;

  typedef struct packed {
    logic [15:0] rd;
    logic        irq;
  } bus_resp_t;

  typedef struct {
    logic [2:0]  fn;
    logic [1:0]  off;
    logic [15:0] dat;
    bit          typed;
    logic [15:0] rd;
    logic        irq;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [1:0] reg_offset, [17:2] data_in, [23:18] zero
  logic [2:0]  in_tuser;   // [2:0] func
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [15:0] read_data, [16] irq_out, [23:17] zero

  logic        no_idle;
  int unsigned cyc_cnt;
  int unsigned fail_cnt;
  int unsigned items_in;
  int unsigned resp_seen;
  int unsigned drop_cnt;
  int unsigned empty_rd_cnt;
  int unsigned mreset_cnt;

  // Predictor state: receive ring, pointers and the byte registers.
  logic [7:0]       rx_mem [RING_DEPTH_DEF];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [7:0]       sr;
  logic [7:0]       cr;
  logic [7:0]       tx_byte;

  bus_resp_t resp_q [$];

  // Directed rows. The push run fills the ring to 15 bytes, then one is dropped.
  stim_row_t dir_tab [28] = '{
    '{FN_BYTE_RD, 2'd0, 16'h0000, 1'b1, 16'h008F, 1'b1},
    '{FN_BYTE_RD, 2'd2, 16'h0000, 1'b1, 16'h00F0, 1'b1},
    '{FN_WORD_RD, 2'd3, 16'hFFFF, 1'b1, 16'h0101, 1'b0},
    '{FN_BYTE_RD, 2'd2, 16'h0000, 1'b1, 16'h00FF, 1'b0},
    '{FN_WORD_RD, 2'd1, 16'h0000, 1'b1, 16'h0E0E, 1'b0},
    '{FN_BYTE_WR, 2'd2, 16'h0080, 1'b1, 16'h0000, 1'b1},
    '{FN_PUSH,    2'd0, 16'hFFFF, 1'b1, 16'h0000, 1'b1},
    '{FN_PUSH,    2'd1, 16'h0000, 1'b1, 16'h0000, 1'b1},
    '{FN_PUSH,    2'd2, 16'hAA55, 1'b1, 16'h0000, 1'b1},
    '{FN_PUSH,    2'd3, 16'h55AA, 1'b1, 16'h0000, 1'b1},
    '{FN_PUSH,    2'd0, 16'h0001, 1'b1, 16'h0000, 1'b1},
    '{FN_PUSH,    2'd1, 16'hFF80, 1'b1, 16'h0000, 1'b1},
    '{FN_PUSH,    2'd2, 16'h7F7F, 1'b1, 16'h0000, 1'b1},
    '{FN_PUSH,    2'd3, 16'h8000, 1'b1, 16'h0000, 1'b1},
    '{FN_PUSH,    2'd0, 16'h0102, 1'b1, 16'h0000, 1'b1},
    '{FN_PUSH,    2'd1, 16'hC3FE, 1'b1, 16'h0000, 1'b1},
    '{FN_PUSH,    2'd2, 16'h3C03, 1'b1, 16'h0000, 1'b1},
    '{FN_PUSH,    2'd3, 16'h1240, 1'b1, 16'h0000, 1'b1},
    '{FN_PUSH,    2'd0, 16'hEDCB, 1'b1, 16'h0000, 1'b1},
    '{FN_PUSH,    2'd3, 16'h5A33, 1'b1, 16'h0000, 1'b1},
    '{FN_BYTE_RD, 2'd0, 16'h0000, 1'b1, 16'h008F, 1'b1},
    '{FN_WORD_RD, 2'd2, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{FN_BYTE_WR, 2'd1, 16'h0054, 1'b1, 16'h0000, 1'b1},
    '{FN_BYTE_WR, 2'd0, 16'h00FF, 1'b1, 16'h0000, 1'b1},
    '{FN_WORD_WR, 2'd3, 16'h8003, 1'b0, 16'h0000, 1'b0},
    '{FN_WORD_WR, 2'd2, 16'h1280, 1'b0, 16'h0000, 1'b0},
    '{3'd5,       2'd1, 16'hFFFF, 1'b1, 16'h0000, 1'b1},
    '{3'd7,       2'd2, 16'h0000, 1'b1, 16'h0000, 1'b1}
  };

  keyboard_uart_receive_fifo_model #(
    .RING_DEPTH(RING_DEPTH_DEF)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic logic [IDX_W-1:0] ring_adv(logic [IDX_W-1:0] i);
    return (i == IDX_W'(RING_DEPTH_DEF - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic void rx_put(logic [7:0] b);
    if (ring_adv(wr_ptr) == rd_ptr) begin
      drop_cnt++;
      return;
    end
    rx_mem[wr_ptr] = b;
    wr_ptr = ring_adv(wr_ptr);
    sr[SR_RDRF] = 1'b1;
    sr[SR_IRQ]  = 1'b1;
  endfunction

  function automatic void queue_hello();
    rx_put(HELLO_B0);
    rx_put(HELLO_B1);
  endfunction

  function automatic logic [7:0] reg_read(logic [1:0] off);
    logic [7:0] d;
    if (!off[1])
      return sr;
    if (wr_ptr == rd_ptr) begin
      empty_rd_cnt++;
      return EMPTY_BYTE;
    end
    d = rx_mem[rd_ptr];
    rd_ptr = ring_adv(rd_ptr);
    if (wr_ptr == rd_ptr)
      sr[SR_RDRF] = 1'b0;
    sr[SR_IRQ] = sr[SR_RDRF];
    return d;
  endfunction

  function automatic void reg_write(logic [1:0] off, logic [7:0] v);
    if (!off[1]) begin
      if (v[1:0] == CR_MRESET) begin
        mreset_cnt++;
        sr     = SR_MRESET;
        wr_ptr = '0;
        rd_ptr = '0;
        queue_hello();
      end
      cr = v;
    end else begin
      tx_byte = v;
      if (v == TX_HELLO)
        queue_hello();
      sr[SR_TDRE] = 1'b1;
      sr[SR_IRQ]  = sr[SR_RDRF];
    end
  endfunction

  function automatic void model_reset();
    foreach (rx_mem[i]) rx_mem[i] = 8'h00;
    wr_ptr  = '0;
    rd_ptr  = '0;
    sr      = SR_MRESET;
    cr      = 8'h00;
    tx_byte = 8'h00;
    queue_hello();
  endfunction

  function automatic bus_resp_t bus_step(logic [2:0] fn, logic [1:0] off, logic [15:0] dat);
    bus_resp_t r;
    logic [7:0] b;
    r.rd = 16'h0000;
    case (fn)
      FN_BYTE_RD: r.rd = {8'h00, reg_read(off)};
      FN_BYTE_WR: reg_write(off, dat[7:0]);
      FN_WORD_RD: begin
        b = reg_read(off);
        r.rd = {b, b};
      end
      FN_WORD_WR: begin
        reg_write(off, dat[15:8]);
        reg_write(off + 2'd1, dat[7:0]);
      end
      FN_PUSH: rx_put(dat[7:0]);
      default: ;
    endcase
    r.irq = sr[SR_IRQ];
    return r;
  endfunction

  // Offer one item, hold it until the transfer, then queue what it should give back.
  task automatic drive_item(input logic [2:0] fn, input logic [1:0] off,
                            input logic [15:0] dat, input bit typed,
                            input logic [15:0] rd, input logic irq);
    bus_resp_t want;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {6'd0, dat, off};
    do @(posedge clk); while (!in_tready);
    want = bus_step(fn, off, dat);
    if (typed) begin
      want.rd  = rd;
      want.irq = irq;
    end
    resp_q.push_back(want);
    items_in++;
  endtask

  // mode 0 balanced, 1 fills the ring, 2 drains it
  task automatic rand_item(input int unsigned mode, output logic [2:0] fn,
                           output logic [1:0] off, output logic [15:0] dat);
    int unsigned r;
    int unsigned push_w;
    int unsigned pop_w;
    r      = $urandom_range(99);
    push_w = (mode == 1) ? 60 : (mode == 2) ? 15 : 30;
    pop_w  = (mode == 2) ? 55 : (mode == 1) ? 15 : 25;
    off    = 2'($urandom_range(3));
    dat    = 16'($urandom);
    if (r < push_w) begin
      fn = FN_PUSH;
    end else if (r < push_w + pop_w) begin
      fn = $urandom_range(1) ? FN_WORD_RD : FN_BYTE_RD;
      off[1] = 1'b1;
    end else if (r < 84) begin
      fn = $urandom_range(1) ? FN_WORD_RD : FN_BYTE_RD;
    end else if (r < 96) begin
      fn = $urandom_range(1) ? FN_WORD_WR : FN_BYTE_WR;
      if ($urandom_range(3) == 0) dat[7:0]  = TX_HELLO;
      if ($urandom_range(3) == 0) dat[15:8] = TX_HELLO;
    end else begin
      fn = 3'($urandom_range(7, 5));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > MAX_CYC) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cyc_cnt, resp_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Response side: check each transfer out, then choose the next ready.
  always @(posedge clk) begin
    bus_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      resp_seen++;
      if (resp_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_SHOWN)
          $display("unexpected response rd=%h irq=%b", out_tdata[15:0], out_tdata[16]);
      end else begin
        want = resp_q.pop_front();
        if (out_tdata[15:0] !== want.rd || out_tdata[16] !== want.irq) begin
          fail_cnt++;
          if (fail_cnt <= MAX_SHOWN)
            $display("response %0d: expected rd=%h irq=%b, got rd=%h irq=%b",
                     resp_seen, want.rd, want.irq, out_tdata[15:0], out_tdata[16]);
        end
      end
    end
    out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    int unsigned mode;
    logic [2:0]  fn;
    logic [1:0]  off;
    logic [15:0] dat;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tuser     = '0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    no_idle      = 1'b0;
    cyc_cnt      = 0;
    fail_cnt     = 0;
    items_in     = 0;
    resp_seen    = 0;
    drop_cnt     = 0;
    empty_rd_cnt = 0;
    mreset_cnt   = 0;
    mode         = 0;
    model_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      drive_item(dir_tab[i].fn, dir_tab[i].off, dir_tab[i].dat,
                 dir_tab[i].typed, dir_tab[i].rd, dir_tab[i].irq);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 60 == 0) mode = $urandom_range(2);
      // hold both sides busy through one long stretch
      no_idle <= (n >= 300 && n < 420);
      rand_item(mode, fn, off, dat);
      drive_item(fn, off, dat, 1'b0, 16'h0000, 1'b0);
    end
    in_tvalid <= 1'b0;
    no_idle   <= 1'b0;

    while (resp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bus and push transfers, checked %0d responses", items_in, resp_seen);
    $display("Saw %0d dropped pushes, %0d empty data reads, %0d master resets",
             drop_cnt, empty_rd_cnt, mreset_cnt);
    if (fail_cnt == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
